// ----- src/osc_pkg.sv -----
// Package with the shared widths, register map and configuration type of the oscillation detector.
`timescale 1ns / 1ps

package osc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAG_BITS    = SAMPLE_BITS;
    localparam int LIMIT_BITS  = 8;
    localparam int HYST_BITS   = 15;
    localparam int MS_BITS     = 16;
    localparam int EDGE_BITS   = 8;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_EDGE_LIMIT = 2'd0;
    localparam logic [1:0] REG_HYSTERESIS = 2'd1;
    localparam logic [1:0] REG_WINDOW_MS  = 2'd2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(3);
    localparam logic [HYST_BITS-1:0]  HYST_RESET   = HYST_BITS'(256);
    localparam logic [MS_BITS-1:0]    WINDOW_RESET = MS_BITS'(1000);

    // Item kinds carried on the cmd field.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] edge_count_limit;
        logic [HYST_BITS-1:0]  hysteresis_offset;
        logic [MS_BITS-1:0]    window_ms;
    } cfg_t;

endpackage

// ----- src/osc_in_if.sv -----
// Input channel interface: sample or tick words with valid and ready.
`timescale 1ns / 1ps

interface osc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [osc_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

// ----- src/osc_out_if.sv -----
// Output channel interface: alarm words with valid and ready.
`timescale 1ns / 1ps

interface osc_out_if;
    logic valid;
    logic ready;
    logic oscillating;

    modport source (output valid, output oscillating, input ready);
    modport sink   (input valid, input oscillating, output ready);
endinterface

// ----- src/osc_cfg.sv -----
// APB register bank holding the edge limit, hysteresis offset and window length.
`timescale 1ns / 1ps

module osc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [osc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [osc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [osc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output osc_pkg::cfg_t                      cfg
);

    logic [osc_pkg::LIMIT_BITS-1:0] limit_reg;
    logic [osc_pkg::HYST_BITS-1:0]  hyst_reg;
    logic [osc_pkg::MS_BITS-1:0]    window_reg;
    logic [1:0]                     index;
    logic                           wr_en;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= osc_pkg::LIMIT_RESET;
            hyst_reg   <= osc_pkg::HYST_RESET;
            window_reg <= osc_pkg::WINDOW_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                osc_pkg::REG_EDGE_LIMIT: limit_reg  <= pwdata[osc_pkg::LIMIT_BITS-1:0];
                osc_pkg::REG_HYSTERESIS: hyst_reg   <= pwdata[osc_pkg::HYST_BITS-1:0];
                osc_pkg::REG_WINDOW_MS:  window_reg <= pwdata[osc_pkg::MS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            osc_pkg::REG_EDGE_LIMIT:
                prdata = osc_pkg::APB_DATA_BITS'(limit_reg);
            osc_pkg::REG_HYSTERESIS:
                prdata = osc_pkg::APB_DATA_BITS'(hyst_reg);
            osc_pkg::REG_WINDOW_MS:
                prdata = osc_pkg::APB_DATA_BITS'(window_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.edge_count_limit  = limit_reg;
    assign cfg.hysteresis_offset = hyst_reg;
    assign cfg.window_ms         = window_reg;

endmodule

// ----- src/osc_core.sv -----
// Detector state: magnitude classification, edge counters, alarm latch and window timer.
`timescale 1ns / 1ps

module osc_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_acc,
    input  logic                                   cmd,
    input  logic signed [osc_pkg::SAMPLE_BITS-1:0] sample,
    input  osc_pkg::cfg_t                          cfg,
    output logic                                   alarm
);

    localparam int MB = osc_pkg::MAG_BITS;
    localparam int EB = osc_pkg::EDGE_BITS;
    localparam int TB = osc_pkg::MS_BITS;

    logic          primed_reg,  primed_next;
    logic [MB-1:0] last_reg,    last_next;
    logic          rprev_reg,   rprev_next;
    logic          fprev_reg,   fprev_next;
    logic [EB-1:0] redges_reg,  redges_next;
    logic [EB-1:0] fedges_reg,  fedges_next;
    logic          latched_reg, latched_next;
    logic [TB-1:0] elapsed_reg, elapsed_next;

    logic [MB-1:0] mag;
    logic [MB-1:0] last_eff;
    logic [MB:0]   up_thr;
    logic [MB:0]   mag_plus;
    logic          rising;
    logic          falling;
    logic          rise_inc;
    logic          fall_inc;
    logic [EB-1:0] redges_upd;
    logic [EB-1:0] fedges_upd;
    logic [TB-1:0] elapsed_upd;
    logic          hit;
    logic          alarm_raw;
    logic          expire;

    // The two's complement of the most negative sample is its own magnitude as unsigned.
    assign mag      = sample[osc_pkg::SAMPLE_BITS-1] ? MB'(-sample) : MB'(sample);
    assign last_eff = primed_reg ? last_reg : mag;
    assign up_thr   = {1'b0, last_eff} + (MB+1)'(cfg.hysteresis_offset);
    assign mag_plus = {1'b0, mag} + (MB+1)'(cfg.hysteresis_offset);
    assign rising   = ({1'b0, mag} > up_thr);
    assign falling  = !rising && (mag_plus < {1'b0, last_eff});

    assign rise_inc = rising && !rprev_reg;
    assign fall_inc = !rise_inc && falling && !fprev_reg;

    assign redges_upd = (rise_inc && redges_reg != '1) ? redges_reg + 1'b1 : redges_reg;
    assign fedges_upd = (fall_inc && fedges_reg != '1) ? fedges_reg + 1'b1 : fedges_reg;
    assign hit = (redges_upd >= cfg.edge_count_limit) && (fedges_upd >= cfg.edge_count_limit);

    assign elapsed_upd = (cmd == osc_pkg::CMD_TICK && elapsed_reg != '1)
                       ? elapsed_reg + 1'b1 : elapsed_reg;
    assign expire      = (elapsed_upd > cfg.window_ms);

    always_comb
    begin
        primed_next  = primed_reg;
        last_next    = last_reg;
        rprev_next   = rprev_reg;
        fprev_next   = fprev_reg;
        redges_next  = redges_reg;
        fedges_next  = fedges_reg;
        latched_next = latched_reg;
        elapsed_next = elapsed_upd;
        alarm_raw    = 1'b0;
        if (cmd == osc_pkg::CMD_SAMPLE)
        begin
            primed_next  = 1'b1;
            last_next    = mag;
            rprev_next   = rising;
            fprev_next   = falling;
            redges_next  = redges_upd;
            fedges_next  = fedges_upd;
            alarm_raw    = hit && !latched_reg;
            latched_next = latched_reg | hit;
        end
        if (expire)
        begin
            redges_next  = '0;
            fedges_next  = '0;
            latched_next = 1'b0;
            elapsed_next = '0;
        end
    end

    assign alarm = alarm_raw && !expire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg  <= 1'b0;
            last_reg    <= '0;
            rprev_reg   <= 1'b0;
            fprev_reg   <= 1'b0;
            redges_reg  <= '0;
            fedges_reg  <= '0;
            latched_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (in_acc)
        begin
            primed_reg  <= primed_next;
            last_reg    <= last_next;
            rprev_reg   <= rprev_next;
            fprev_reg   <= fprev_next;
            redges_reg  <= redges_next;
            fedges_reg  <= fedges_next;
            latched_reg <= latched_next;
            elapsed_reg <= elapsed_next;
        end
    end

`ifndef SYNTH
    // A raised alarm always leaves the latch set so it cannot fire twice.
    a_alarm_latches: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && alarm |=> latched_reg)
        else $error("alarm raised without setting the latch");

    // Ticks never raise the alarm.
    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && cmd == osc_pkg::CMD_TICK |-> !alarm)
        else $error("alarm raised on a tick word");

    // Window expiry wipes counters, latch and timer together.
    a_expire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && expire |=> redges_reg == '0 && fedges_reg == '0
                             && !latched_reg && elapsed_reg == '0)
        else $error("window expiry did not clear detector state");
`endif

endmodule

// ----- src/osc_out_buf.sv -----
// Two-entry result buffer that decouples the output handshake from the input side.
`timescale 1ns / 1ps

module osc_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            push_data,
    output logic            ready,
    osc_out_if.source       out_ch
);

    logic [1:0] data_reg;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign ready              = (count_reg != 2'd2);
    assign out_ch.valid       = (count_reg != 2'd0);
    assign out_ch.oscillating = data_reg[rd_ptr_reg];
    assign pop                = out_ch.valid & out_ch.ready;

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/oscillation_detector_top.sv -----
// Top level of the oscillation detector: register bank, detector core and result buffer.
// Each result word is written into the result buffer as its input word is accepted.
// Throughput: one input word per cycle while the result buffer has room.
// The two-entry result buffer keeps input ready high while one result waits to be taken.
// Reset (rst_n, asynchronous, active low) clears all detector state, empties the result
// buffer and loads the registers with edge limit 3, hysteresis 256 and window 1000 ms.
`timescale 1ns / 1ps

module oscillation_detector_top (
    input  logic                               clk,
    input  logic                               rst_n,
    osc_in_if.sink                             in_ch,
    osc_out_if.source                          out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [osc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [osc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [osc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    osc_pkg::cfg_t cfg;
    logic          buf_ready;
    logic          in_acc;
    logic          alarm;

    // Every accepted word yields exactly one result word, so input ready simply
    // follows room in the result buffer.
    assign in_ch.ready = buf_ready;
    assign in_acc      = in_ch.valid & buf_ready;

    osc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The core classifies the sample, updates the counters and timer, and decides
    // the alarm in the cycle the word is accepted.
    osc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_acc (in_acc),
        .cmd    (in_ch.cmd),
        .sample (in_ch.sample),
        .cfg    (cfg),
        .alarm  (alarm)
    );

    // The alarm bit is registered into the buffer, which presents it on the output.
    osc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_acc),
        .push_data (alarm),
        .ready     (buf_ready),
        .out_ch    (out_ch)
    );

endmodule
